// ===== design/assert_macros.svh =====
// Assertion macros shared by the RTL files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked at every rising clock edge, off during reset
`define CHK_IMPL(label, clk, rst, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
    else $error("check failed");
// Next-cycle implication, off during reset
`define CHK_NEXT(label, clk, rst, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
    else $error("check failed");
`endif

// ===== design/sacl_pkg.sv =====
// Package: types, sizes and codes of the set-associative cache controller
`timescale 1ns / 1ps
`default_nettype none
package sacl_pkg;
  localparam int NUM_SETS   = 64;
  localparam int NUM_WAYS   = 8;
  localparam int LINE_BYTES = 64;
  localparam int COUNT_BITS = 16;

  localparam int OFF_BITS  = $clog2(LINE_BYTES);
  localparam int SET_BITS  = (NUM_SETS > 1) ? $clog2(NUM_SETS) : 1;
  localparam int SET_W     = $clog2(NUM_SETS);
  localparam int TAG_BITS  = 32 - OFF_BITS - SET_W;
  localparam int WAY_BITS  = (NUM_WAYS > 1) ? $clog2(NUM_WAYS) : 1;
  localparam int CNT_MAX   = (1 << COUNT_BITS) - 1;
  // one row word per way: valid, dirty, tag, count
  localparam int WAY_W     = 2 + TAG_BITS + COUNT_BITS;
  localparam int ROW_W     = WAY_W * NUM_WAYS;

  localparam logic [1:0] KIND_RESP  = 2'd0;
  localparam logic [1:0] KIND_WB    = 2'd1;
  localparam logic [1:0] KIND_FETCH = 2'd2;
  localparam logic [1:0] KIND_FWD   = 2'd3;

  localparam logic REG_WT = 1'b0;
  localparam logic REG_WA = 1'b1;

  localparam logic [6:0] LINE_BYTES7 = 7'(LINE_BYTES);

  typedef struct packed {
    logic        op;
    logic [31:0] address;
    logic [3:0]  nbytes;
  } req_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] lower_addr;
    logic [6:0]  lower_bytes;
    logic        hit;
    logic [2:0]  way;
    logic        last;
  } rsp_t;

  typedef struct packed {
    logic                valid;
    logic                dirty;
    logic [TAG_BITS-1:0] tag;
    logic [COUNT_BITS-1:0] count;
  } way_t;

  // controller to datapath
  typedef struct packed {
    logic load;      // capture request, start row read
    logic clr;       // clearing pass write
    logic decide;    // row data valid: evaluate and write back
    logic [2:0] emit_sel; // which item to present
    logic emit;
  } ctl_t;

  localparam logic [2:0] EM_WB   = 3'd0;
  localparam logic [2:0] EM_FET  = 3'd1;
  localparam logic [2:0] EM_FWD  = 3'd2;
  localparam logic [2:0] EM_RESP = 3'd3;

  // datapath to controller
  typedef struct packed {
    logic need_wb;
    logic need_fet;
    logic need_fwd;
  } sts_t;
endpackage
`default_nettype wire

// ===== design/set_assoc_cache_lfu_controller.sv =====
// Top level: set-associative cache tag controller with LFU replacement
// After reset the block clears its tag rows, one set a cycle, through all
// NUM_SETS (64) sets with busy high; configuration writes are taken meanwhile.
// An access is taken when start is high and busy low; from start to final
// response it passes through tag row read, decision and row write-back, then
// one slot each for write-back, fetch, forwarded write and response; the
// slots for items that do not arise stay silent. Results appear on result
// for one cycle with strobe high and cannot be held off; the response is
// always the last transfer of an access, marked by result.last. busy is
// already low while the response is shown, so the next access may be taken
// at the edge that ends it.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module set_assoc_cache_lfu_controller import sacl_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  output logic             busy,
  input  wire req_t        request,
  output logic             strobe,
  output rsp_t             result,
  input  wire logic        cfg_we,
  input  wire logic        cfg_index,
  input  wire logic        cfg_wdata
);
  logic                wt_mode;
  logic                wa_mode;
  ctl_t                ctl;
  sts_t                sts;
  logic [SET_BITS-1:0] clr_addr;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      wt_mode <= 1'b0;
      wa_mode <= 1'b1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_WT: wt_mode <= cfg_wdata;
        REG_WA: wa_mode <= cfg_wdata;
        default: ;
      endcase
    end
  end

  sacl_ctrl u_ctrl (
    .clk(clk), .rst(rst), .start(start), .sts(sts),
    .ctl(ctl), .busy(busy), .clr_addr(clr_addr)
  );

  sacl_dp u_dp (
    .clk(clk), .rst(rst), .req(request), .wt_mode(wt_mode), .wa_mode(wa_mode),
    .ctl(ctl), .clr_addr(clr_addr), .sts(sts), .rsp(result), .strobe(strobe)
  );

  `CHK_IMPL(a_item_while_busy, clk, rst, strobe && !result.last, busy)
  `CHK_NEXT(a_busy_after_start, clk, rst, start && !busy, busy)
  `CHK_IMPL(a_last_is_resp, clk, rst, strobe && result.last, result.kind == KIND_RESP)
  `CHK_IMPL(a_resp_when_idle, clk, rst, strobe && result.last, !busy)
endmodule
`default_nettype wire

// ===== design/sacl_ram.sv =====
// Generic single-port-write, registered-read RAM
`timescale 1ns / 1ps
`default_nettype none
module sacl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// ===== design/sacl_dp.sv =====
// Datapath: request register, tag row RAM, hit/victim logic, result register
`timescale 1ns / 1ps
`default_nettype none
module sacl_dp import sacl_pkg::*; (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire req_t                req,
  input  wire logic                wt_mode,
  input  wire logic                wa_mode,
  input  wire ctl_t                ctl,
  input  wire logic [SET_BITS-1:0] clr_addr,
  output sts_t                     sts,
  output rsp_t                     rsp,
  output logic                     strobe
);
  req_t                cur;
  logic [ROW_W-1:0]    row_rd;
  logic [ROW_W-1:0]    row_wr;
  way_t                ways [NUM_WAYS];
  way_t                upd;
  logic [SET_BITS-1:0] set_idx;
  logic [SET_BITS-1:0] cur_set;
  logic [TAG_BITS-1:0] cur_tag;
  logic                hit_any;
  logic [WAY_BITS-1:0] hit_way;
  logic                free_any;
  logic [WAY_BITS-1:0] free_way;
  logic [WAY_BITS-1:0] lfu_way;
  logic [COUNT_BITS-1:0] lfu_cnt;
  logic [WAY_BITS-1:0] sel_way;
  logic                is_wr;
  logic                noalloc;
  logic                we;
  rsp_t                rsp_next;
  // decision registers held for item emission
  logic                d_hit;
  logic [WAY_BITS-1:0] d_way;
  logic [31:0]         d_wb_addr;

  always_comb begin
    if (NUM_SETS > 1) set_idx = req.address[OFF_BITS +: SET_BITS];
    else              set_idx = '0;
    if (NUM_SETS > 1) cur_set = cur.address[OFF_BITS +: SET_BITS];
    else              cur_set = '0;
  end
  assign cur_tag = cur.address[31 -: TAG_BITS];
  assign is_wr   = cur.op;

  always_ff @(posedge clk) begin
    if (ctl.load) cur <= req;
  end

  // row read from the request on the transfer, from the held request after it
  sacl_ram #(.WIDTH(ROW_W), .DEPTH(NUM_SETS)) u_rows (
    .clk  (clk),
    .we   (we),
    .waddr(ctl.clr ? clr_addr : cur_set),
    .wdata(ctl.clr ? '0 : row_wr),
    .raddr(ctl.load ? set_idx : cur_set),
    .rdata(row_rd)
  );

  // unpack the row and look for hit and free way
  always_comb begin
    hit_any  = 1'b0;
    hit_way  = '0;
    free_any = 1'b0;
    free_way = '0;
    for (int w = NUM_WAYS - 1; w >= 0; w--) begin
      ways[w] = row_rd[w*WAY_W +: WAY_W];
      if (ways[w].valid && ways[w].tag == cur_tag) begin
        hit_any = 1'b1;
        hit_way = WAY_BITS'(w);
      end
      if (!ways[w].valid) begin
        free_any = 1'b1;
        free_way = WAY_BITS'(w);
      end
    end
  end

  // smallest use count, lowest index on ties
  always_comb begin
    lfu_way = '0;
    lfu_cnt = ways[0].count;
    for (int w = 1; w < NUM_WAYS; w++) begin
      if (ways[w].count < lfu_cnt) begin
        lfu_cnt = ways[w].count;
        lfu_way = WAY_BITS'(w);
      end
    end
  end

  assign noalloc = !hit_any && is_wr && !wa_mode;
  assign sel_way = hit_any ? hit_way : (free_any ? free_way : lfu_way);

  // updated way entry and the row that goes back
  always_comb begin
    upd = ways[sel_way];
    if (hit_any) begin
      if (upd.count != COUNT_BITS'(CNT_MAX)) upd.count = upd.count + 1'b1;
      if (is_wr && !wt_mode) upd.dirty = 1'b1;
    end else begin
      upd.valid = 1'b1;
      upd.tag   = cur_tag;
      upd.count = '0;
      upd.dirty = is_wr && !wt_mode;
    end
    row_wr = row_rd;
    row_wr[sel_way*WAY_W +: WAY_W] = upd;
  end

  assign we = ctl.clr || (ctl.decide && !noalloc);

  always_ff @(posedge clk) begin
    if (rst) begin
      sts <= '0;
    end else if (ctl.decide) begin
      sts.need_wb  <= !hit_any && !noalloc && !free_any && !wt_mode
                      && ways[lfu_way].dirty;
      sts.need_fet <= !hit_any && !noalloc;
      sts.need_fwd <= is_wr && (wt_mode || noalloc);
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.decide) begin
      d_hit     <= hit_any;
      d_way     <= noalloc ? '0 : sel_way;
      d_wb_addr <= {ways[lfu_way].tag, cur_set[SET_W-1:0], OFF_BITS'(0)};
    end
  end

  // item selected for the next transfer
  always_comb begin
    rsp_next     = '0;
    rsp_next.way = 3'(d_way);
    unique case (ctl.emit_sel)
      EM_WB: begin
        rsp_next.kind        = KIND_WB;
        rsp_next.lower_addr  = d_wb_addr;
        rsp_next.lower_bytes = LINE_BYTES7;
      end
      EM_FET: begin
        rsp_next.kind        = KIND_FETCH;
        rsp_next.lower_addr  = {cur.address[31:OFF_BITS], OFF_BITS'(0)};
        rsp_next.lower_bytes = LINE_BYTES7;
      end
      EM_FWD: begin
        rsp_next.kind        = KIND_FWD;
        rsp_next.lower_addr  = cur.address;
        rsp_next.lower_bytes = 7'(cur.nbytes);
      end
      default: begin
        rsp_next.kind = KIND_RESP;
        rsp_next.hit  = d_hit;
        rsp_next.last = 1'b1;
      end
    endcase
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      strobe <= 1'b0;
    end else begin
      strobe <= ctl.emit;
    end
    if (ctl.emit) rsp <= rsp_next;
  end
endmodule
`default_nettype wire

// ===== design/sacl_ctrl.sv =====
// Controller: clearing pass, access sequencing and item emission order
`timescale 1ns / 1ps
`default_nettype none
module sacl_ctrl import sacl_pkg::*; (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                start,
  input  wire sts_t                sts,
  output ctl_t                     ctl,
  output logic                     busy,
  output logic [SET_BITS-1:0]      clr_addr
);
  localparam logic [2:0] S_CLR  = 3'd0;
  localparam logic [2:0] S_IDLE = 3'd1;
  localparam logic [2:0] S_RD   = 3'd2;
  localparam logic [2:0] S_DEC  = 3'd3;
  localparam logic [2:0] S_WB   = 3'd4;
  localparam logic [2:0] S_FET  = 3'd5;
  localparam logic [2:0] S_FWD  = 3'd6;
  localparam logic [2:0] S_RESP = 3'd7;

  logic [2:0] state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_CLR;
      clr_addr <= '0;
    end else begin
      state <= state_next;
      if (state == S_CLR) clr_addr <= clr_addr + 1'b1;
    end
  end

  always_comb begin
    state_next = state;
    ctl        = '0;
    unique case (state)
      S_CLR: begin
        ctl.clr = 1'b1;
        if (clr_addr == SET_BITS'(NUM_SETS - 1)) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (start) begin
          ctl.load   = 1'b1;
          state_next = S_RD;
        end
      end
      S_RD: state_next = S_DEC;
      S_DEC: begin
        ctl.decide = 1'b1;
        state_next = S_WB;
      end
      S_WB: begin
        ctl.emit_sel = EM_WB;
        ctl.emit     = sts.need_wb;
        state_next   = S_FET;
      end
      S_FET: begin
        ctl.emit_sel = EM_FET;
        ctl.emit     = sts.need_fet;
        state_next   = S_FWD;
      end
      S_FWD: begin
        ctl.emit_sel = EM_FWD;
        ctl.emit     = sts.need_fwd;
        state_next   = S_RESP;
      end
      S_RESP: begin
        ctl.emit_sel = EM_RESP;
        ctl.emit     = 1'b1;
        state_next   = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  assign busy = (state != S_IDLE);
endmodule
`default_nettype wire

// ===== tb/cache_checker.sv =====
// Checker: watches access and result transfers, predicts cache behaviour, compares
`timescale 1ns / 1ps
`default_nettype none
module cache_checker import sacl_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic start,
  input  wire logic busy,
  input  wire req_t request,
  input  wire logic strobe,
  input  wire rsp_t result,
  input  wire logic cfg_we,
  input  wire logic cfg_index,
  input  wire logic cfg_wdata,
  output int        errors,
  output int        pending
);
  // shadow tag state
  logic                  sh_valid [NUM_SETS*NUM_WAYS];
  logic                  sh_dirty [NUM_SETS*NUM_WAYS];
  logic [TAG_BITS-1:0]   sh_tag   [NUM_SETS*NUM_WAYS];
  logic [COUNT_BITS-1:0] sh_count [NUM_SETS*NUM_WAYS];
  logic wt_mode, wa_mode;
  // ring of expected transfers
  rsp_t       exp_buf [16];
  logic [3:0] exp_head, exp_tail;
  int         exp_count;

  assign pending = exp_count;

  task automatic report_mismatch(input string what, input rsp_t got, input rsp_t want);
    $display("%0t mismatch %s: got %h want %h", $realtime, what, got, want);
    errors++;
  endtask

  function automatic rsp_t mk(input logic [1:0] k, input logic [31:0] a, input logic [6:0] b,
                              input logic h, input logic [2:0] w, input logic l);
    rsp_t r;
    r.kind = k; r.lower_addr = a; r.lower_bytes = b; r.hit = h; r.way = w; r.last = l;
    return r;
  endfunction

  task automatic add_expected(input rsp_t r);
    exp_buf[exp_tail] = r;
    exp_tail = exp_tail + 4'd1;
    exp_count++;
  endtask

  // predict the transfers caused by one access
  task automatic predict_access(input req_t q);
    logic [5:0] set;
    logic [TAG_BITS-1:0] tag;
    int base, hw, fw, w, e;
    logic [COUNT_BITS-1:0] best;
    set = q.address[OFF_BITS +: SET_W];
    tag = q.address[31 -: TAG_BITS];
    base = set * NUM_WAYS;
    hw = -1; fw = -1;
    for (int i = 0; i < NUM_WAYS; i++) begin
      if (hw < 0 && sh_valid[base+i] && sh_tag[base+i] == tag) hw = i;
      if (hw < 0 && fw < 0 && !sh_valid[base+i]) fw = i;
    end
    if (hw >= 0) begin
      e = base + hw;
      if (sh_count[e] != CNT_MAX) sh_count[e]++;
      if (q.op) begin
        if (wt_mode)
          add_expected(mk(KIND_FWD, q.address, 7'(q.nbytes), 1'b0, 3'(hw), 1'b0));
        else sh_dirty[e] = 1'b1;
      end
      add_expected(mk(KIND_RESP, 32'd0, 7'd0, 1'b1, 3'(hw), 1'b1));
      return;
    end
    if (q.op && !wa_mode) begin
      add_expected(mk(KIND_FWD, q.address, 7'(q.nbytes), 1'b0, 3'd0, 1'b0));
      add_expected(mk(KIND_RESP, 32'd0, 7'd0, 1'b0, 3'd0, 1'b1));
      return;
    end
    if (fw >= 0) w = fw;
    else begin
      w = 0; best = sh_count[base];
      for (int i = 1; i < NUM_WAYS; i++)
        if (sh_count[base+i] < best) begin best = sh_count[base+i]; w = i; end
      if (!wt_mode && sh_dirty[base+w])
        add_expected(mk(KIND_WB, {sh_tag[base+w], set, 6'd0}, LINE_BYTES7, 1'b0, 3'(w),
                        1'b0));
    end
    add_expected(mk(KIND_FETCH, {q.address[31:6], 6'd0}, LINE_BYTES7, 1'b0, 3'(w), 1'b0));
    e = base + w;
    sh_valid[e] = 1'b1; sh_tag[e] = tag; sh_count[e] = '0; sh_dirty[e] = 1'b0;
    if (q.op) begin
      if (wt_mode) add_expected(mk(KIND_FWD, q.address, 7'(q.nbytes), 1'b0, 3'(w), 1'b0));
      else sh_dirty[e] = 1'b1;
    end
    add_expected(mk(KIND_RESP, 32'd0, 7'd0, 1'b0, 3'(w), 1'b1));
  endtask

  initial begin
    errors = 0;
    exp_head = '0; exp_tail = '0; exp_count = 0;
  end

  always @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_SETS*NUM_WAYS; i++) begin
        sh_valid[i] = 1'b0; sh_dirty[i] = 1'b0; sh_tag[i] = '0; sh_count[i] = '0;
      end
      wt_mode = 1'b0; wa_mode = 1'b1;
      exp_head = '0; exp_tail = '0; exp_count = 0;
    end else begin
      // a result transfer is compared before a new access is predicted
      if (strobe) begin
        if (exp_count == 0) report_mismatch("unexpected", result, '0);
        else begin
          rsp_t want;
          want = exp_buf[exp_head];
          exp_head = exp_head + 4'd1;
          exp_count--;
          if (result.kind != want.kind || result.lower_addr != want.lower_addr ||
              result.lower_bytes != want.lower_bytes || result.hit != want.hit ||
              result.way != want.way || result.last != want.last)
            report_mismatch("field", result, want);
        end
      end
      if (cfg_we) begin
        if (cfg_index == REG_WT) wt_mode = cfg_wdata;
        else wa_mode = cfg_wdata;
      end
      if (start && !busy) predict_access(request);
    end
  end
endmodule
`default_nettype wire

// ===== tb/tb.sv =====
// Testbench top: clock, reset, access stimulus, configuration phases and verdict
`timescale 1ns / 1ps
`default_nettype none
module tb;
  import sacl_pkg::*;
  logic clk, rst, start, busy, strobe, cfg_we, cfg_index, cfg_wdata;
  req_t request;
  rsp_t result;
  int errors, pending, n_acc, n_calm;
  logic [31:0] hot_addr [16];

  set_assoc_cache_lfu_controller u_dut (.*);
  cache_checker u_chk (.*);

  initial begin
    clk = 0;
    forever #4 clk = ~clk;
  end

  initial begin
    #20ms;
    $display("tb: failure");
    $finish;
  end

  // one access transfer, with random idle cycles unless in the calm stretch
  task automatic do_access(input logic op, input logic [31:0] a, input logic [3:0] nb);
    while (n_calm == 0 && $urandom_range(99) < 11) @(negedge clk);
    while (busy) @(negedge clk);
    start <= 1'b1; request <= '{op: op, address: a, nbytes: nb};
    @(negedge clk);
    start <= 1'b0;
    n_acc++;
    if (n_calm > 0) n_calm--;
  endtask

  task automatic write_reg(input logic idx, input logic v);
    while (pending != 0) @(negedge clk);
    repeat (10) @(negedge clk);
    cfg_we <= 1'b1; cfg_index <= idx; cfg_wdata <= v;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // mostly a small pool of lines in few sets so hits, evictions and dirty victims occur
  function automatic logic [31:0] pick_addr();
    logic [31:0] a;
    a = hot_addr[$urandom_range(15)];
    a[5:0] = 6'($urandom_range(63));
    if ($urandom_range(9) == 0) a = $urandom;
    return a;
  endfunction

  initial begin
    start = 0; request = '0; cfg_we = 0; cfg_index = 0; cfg_wdata = 0;
    n_acc = 0; n_calm = 0; rst = 1;
    for (int i = 0; i < 16; i++)
      hot_addr[i] = {20'($urandom_range(11)), 6'($urandom_range(1)), 6'd0};
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 0;
    // directed: field extremes, hits, fills, eviction of a dirty way
    do_access(1'b0, 32'h0, 4'd1);
    do_access(1'b1, 32'hFFFF_FFFF, 4'd8);
    do_access(1'b0, 32'hFFFF_FFFF, 4'd15);
    do_access(1'b1, 32'h0000_003F, 4'd0);
    for (int i = 0; i < 9; i++) do_access(1'b1, {20'(i + 1), 6'd5, 6'd0}, 4'd4);
    do_access(1'b0, {20'd9, 6'd5, 6'd0}, 4'd2);
    write_reg(REG_WT, 1'b1);
    do_access(1'b1, {20'd9, 6'd5, 6'd8}, 4'd3);
    do_access(1'b0, {20'd30, 6'd5, 6'd0}, 4'd1);
    do_access(1'b1, {20'd31, 6'd5, 6'd0}, 4'd8);
    write_reg(REG_WA, 1'b0);
    do_access(1'b1, 32'hA5A5_5A5A, 4'd7);
    do_access(1'b1, {20'd31, 6'd5, 6'd0}, 4'd1);
    // random phases through all mode settings; one stretch without idling
    for (int ph = 0; ph < 8; ph++) begin
      write_reg(REG_WT, ph[0]);
      write_reg(REG_WA, ph[1]);
      if (ph == 3) n_calm = 40;
      for (int k = 0; k < 45; k++)
        do_access(1'($urandom_range(1)), pick_addr(), 4'($urandom_range(1, 8)));
    end
    while (pending != 0) @(negedge clk);
    repeat (20) @(negedge clk);
    $display("tb: %0d accesses over all write-through/allocate settings, mismatches %0d",
             n_acc, errors);
    if (errors == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end
endmodule
`default_nettype wire
